>>> rtl/rsic_pkg.sv
// Shared opcodes, item classes and payload types of the instruction core.
`timescale 1ns / 1ps
package rsic_pkg;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;

    localparam logic [31:0] HALT_WORD      = 32'hFFFF_FFFF;
    localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;
    localparam logic [31:0] SEXT_HIGH      = 32'hFFFF_0000;

    localparam logic [1:0] CMD_EXEC      = 2'd0;
    localparam logic [1:0] CMD_LOAD_BYTE = 2'd1;
    localparam logic [1:0] CMD_READ_BYTE = 2'd2;
    localparam logic [1:0] CMD_READ_REG  = 2'd3;

    // Class given to each item by the front end.
    typedef logic [3:0] t_kind;
    localparam t_kind K_NOP   = 4'd0;
    localparam t_kind K_ALU   = 4'd1;
    localparam t_kind K_ADDIU = 4'd2;
    localparam t_kind K_LW    = 4'd3;
    localparam t_kind K_SW    = 4'd4;
    localparam t_kind K_BEQ   = 4'd5;
    localparam t_kind K_J     = 4'd6;
    localparam t_kind K_HALT  = 4'd7;
    localparam t_kind K_LDB   = 4'd8;
    localparam t_kind K_RDB   = 4'd9;
    localparam t_kind K_RDR   = 4'd10;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] instr;
        logic [15:0] baddr;
        logic [7:0]  bval;
        logic [4:0]  ridx;
    } t_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        reg_write;
        logic [4:0]  reg_dest;
        logic [31:0] reg_value;
        logic [31:0] read_data;
    } t_res;

    localparam int ITEM_W = $bits(t_item);
    localparam int RES_W  = $bits(t_res);

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return v[15] ? (SEXT_HIGH | {16'b0, v}) : {16'b0, v};
    endfunction

endpackage

>>> rtl/rsic_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rsic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rsic_fifo.sv
// Small first-in first-out queue built from flip-flops.
`timescale 1ns / 1ps
module rsic_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/rsic_front.sv
// Front end: takes items, classifies them and queues them for execution.
`timescale 1ns / 1ps
module rsic_front
    import rsic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_hold,
    output logic        o_full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_instruction,
    input  logic [15:0] i_byte_address,
    input  logic [7:0]  i_byte_value,
    input  logic [4:0]  i_reg_index,
    output t_item       o_head,
    output logic        o_valid,
    input  logic        i_pop
);

    t_kind kind;
    t_item new_item;
    logic  q_full;
    logic  q_empty;
    logic [5:0] op;
    logic [5:0] fn;

    assign op = i_instruction[31:26];
    assign fn = i_instruction[5:0];

    always_comb begin
        kind = K_NOP;
        case (i_cmd)
            CMD_LOAD_BYTE: kind = K_LDB;
            CMD_READ_BYTE: kind = K_RDB;
            CMD_READ_REG:  kind = K_RDR;
            default: begin
                if (i_instruction == HALT_WORD) begin
                    kind = K_HALT;
                end else begin
                    case (op)
                        OP_RTYPE: begin
                            if (fn inside {FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_NOR}) begin
                                kind = K_ALU;
                            end
                        end
                        OP_J:     kind = K_J;
                        OP_BEQ:   kind = K_BEQ;
                        OP_ADDIU: kind = K_ADDIU;
                        OP_LW:    kind = K_LW;
                        OP_SW:    kind = K_SW;
                        default:  kind = K_NOP;
                    endcase
                end
            end
        endcase
    end

    assign new_item = '{kind:  kind,
                        instr: i_instruction,
                        baddr: i_byte_address,
                        bval:  i_byte_value,
                        ridx:  i_reg_index};

    // While memory is being cleared the queue takes nothing.
    assign o_full  = q_full | i_hold;
    assign o_valid = ~q_empty;

    rsic_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(2)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push & ~i_hold),
        .i_data (new_item),
        .o_full (q_full),
        .i_pop  (i_pop),
        .o_data (o_head),
        .o_empty(q_empty)
    );

endmodule

>>> rtl/rsic_back.sv
// Back end: register file, banked data memory, program counter and execution sequencer.
`timescale 1ns / 1ps
module rsic_back
    import rsic_pkg::*;
#(
    parameter int DATA_BYTES = 65536
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    input  logic  i_item_valid,
    output logic  o_item_pop,
    input  logic  i_res_room,
    output logic  o_res_push,
    output t_res  o_res,
    output logic  o_clearing
);

    localparam int ROWS = (DATA_BYTES + 3) / 4;
    localparam int AW   = $clog2(ROWS);
    localparam logic [32:0]   LIMIT    = 33'(DATA_BYTES);
    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

    localparam logic [1:0] S_CLR   = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr_row, n_clr_row;
    logic [31:0]   r_pc, n_pc;
    logic          r_halt, n_halt;
    t_item         r_item, n_item;
    logic [4:0]    r_ld_dest, n_ld_dest;
    logic          r_ld_ok, n_ld_ok;
    logic [1:0]    r_ld_off, n_ld_off;

    // Register file: two copies so that rs and rt are read together.
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [4:0]  rf_raddr_a, rf_raddr_b;
    logic [31:0] rf_a, rf_b;

    // Data memory: four byte banks, byte address modulo four picks the bank.
    logic [3:0]    bank_we;
    logic [AW-1:0] bank_waddr [4];
    logic [7:0]    bank_wdata [4];
    logic [AW-1:0] bank_raddr [4];
    logic [7:0]    bank_rdata [4];
    logic [1:0]    bank_k     [4];

    logic [31:0]   imm_sext, pc4, eff, alu_val, ld_word;
    logic [31:0]   head_baddr, item_baddr;
    logic [AW-1:0] head_row, item_row, row_lo, row_hi;
    logic [1:0]    off;
    logic          word_ok, byte_ok, live;
    logic          wr;
    logic [4:0]    dest;
    logic [31:0]   val;

    rsic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(rf_raddr_a), .o_rdata(rf_a)
    );

    rsic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(rf_raddr_b), .o_rdata(rf_b)
    );

    for (genvar g = 0; g < 4; g++) begin : g_bank
        rsic_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .i_clk  (i_clk),
            .i_we   (bank_we[g]),
            .i_waddr(bank_waddr[g]),
            .i_wdata(bank_wdata[g]),
            .i_raddr(bank_raddr[g]),
            .o_rdata(bank_rdata[g])
        );
    end

    assign rf_raddr_a = (i_item.kind == K_RDR) ? i_item.ridx : i_item.instr[25:21];
    assign rf_raddr_b = i_item.instr[20:16];

    assign head_baddr = {16'b0, i_item.baddr};
    assign item_baddr = {16'b0, r_item.baddr};
    assign head_row   = head_baddr[AW+1:2];
    assign item_row   = item_baddr[AW+1:2];
    assign byte_ok    = ({17'b0, r_item.baddr} < LIMIT);

    assign imm_sext = sext16(r_item.instr[15:0]);
    assign pc4      = r_pc + 32'd4;
    assign eff      = rf_a + imm_sext;
    assign word_ok  = (({1'b0, eff} + 33'd3) < LIMIT);
    assign off      = eff[1:0];
    assign row_lo   = eff[AW+1:2];
    assign row_hi   = row_lo + 1'b1;
    assign live     = ~r_halt;

    always_comb begin
        case (r_item.instr[5:0])
            FN_ADDU: alu_val = rf_a + rf_b;
            FN_SUBU: alu_val = rf_a - rf_b;
            FN_AND:  alu_val = rf_a & rf_b;
            FN_OR:   alu_val = rf_a | rf_b;
            FN_NOR:  alu_val = ~(rf_a | rf_b);
            default: alu_val = '0;
        endcase
    end

    // Big-endian word: byte k of the word sits in bank (offset + k) modulo four.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ld_word[31 - 8 * k -: 8] = bank_rdata[2'(r_ld_off + 2'(k))];
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            bank_k[j] = 2'(j) - off;
            if (r_state == S_EXEC) begin
                bank_raddr[j] = (2'(j) >= off) ? row_lo : row_hi;
            end else begin
                bank_raddr[j] = head_row;
            end
            if (r_state == S_CLR) begin
                bank_waddr[j] = r_clr_row;
                bank_wdata[j] = '0;
            end else if (r_item.kind == K_LDB) begin
                bank_waddr[j] = item_row;
                bank_wdata[j] = r_item.bval;
            end else begin
                bank_waddr[j] = (2'(j) >= off) ? row_lo : row_hi;
                bank_wdata[j] = 8'(rf_b >> {~bank_k[j], 3'b000});
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_row = r_clr_row;
        n_pc      = r_pc;
        n_halt    = r_halt;
        n_item    = r_item;
        n_ld_dest = r_ld_dest;
        n_ld_ok   = r_ld_ok;
        n_ld_off  = r_ld_off;
        rf_we     = 1'b0;
        rf_waddr  = '0;
        rf_wdata  = '0;
        bank_we   = '0;
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        wr   = 1'b0;
        dest = '0;
        val  = '0;

        case (r_state)
            S_CLR: begin
                rf_we    = 1'b1;
                rf_waddr = r_clr_row[4:0];
                bank_we  = '1;
                if (r_clr_row == LAST_ROW) begin
                    n_state = S_ISSUE;
                end else begin
                    n_clr_row = r_clr_row + 1'b1;
                end
            end
            S_ISSUE: begin
                // Only one item is in flight, so room seen here is still there at the end.
                if (i_item_valid && i_res_room) begin
                    o_item_pop = 1'b1;
                    n_item     = i_item;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_ISSUE;
                case (r_item.kind)
                    K_LDB: begin
                        if (byte_ok) begin
                            bank_we[r_item.baddr[1:0]] = 1'b1;
                        end
                    end
                    K_RDB: begin
                        if (byte_ok) begin
                            o_res.read_data = {24'b0, bank_rdata[r_item.baddr[1:0]]};
                        end
                    end
                    K_RDR: o_res.read_data = rf_a;
                    K_HALT: n_halt = 1'b1;
                    K_ALU: begin
                        if (live) begin
                            wr   = 1'b1;
                            dest = r_item.instr[15:11];
                            val  = alu_val;
                            n_pc = pc4;
                        end
                    end
                    K_ADDIU: begin
                        if (live) begin
                            wr   = 1'b1;
                            dest = r_item.instr[20:16];
                            val  = eff;
                            n_pc = pc4;
                        end
                    end
                    K_LW: begin
                        if (live) begin
                            n_ld_dest = r_item.instr[20:16];
                            n_ld_ok   = word_ok;
                            n_ld_off  = off;
                            n_pc      = pc4;
                            n_state   = S_LOAD;
                        end
                    end
                    K_SW: begin
                        if (live) begin
                            if (word_ok) begin
                                bank_we = '1;
                            end
                            n_pc = pc4;
                        end
                    end
                    K_BEQ: begin
                        if (live) begin
                            n_pc = (rf_a == rf_b) ? pc4 + {imm_sext[29:0], 2'b00} : pc4;
                        end
                    end
                    K_J: begin
                        if (live) begin
                            n_pc = (pc4 & PC_REGION_MASK) | {4'b0, r_item.instr[25:0], 2'b00};
                        end
                    end
                    default: begin
                        if (live) begin
                            n_pc = pc4;
                        end
                    end
                endcase
                if (wr && dest != '0) begin
                    rf_we    = 1'b1;
                    rf_waddr = dest;
                    rf_wdata = val;
                    o_res.reg_write = 1'b1;
                    o_res.reg_dest  = dest;
                    o_res.reg_value = val;
                end
                o_res.next_pc = n_pc;
                o_res.halted  = n_halt;
                o_res_push    = (n_state == S_ISSUE);
            end
            default: begin
                // Load data has come back from the banks.
                n_state = S_ISSUE;
                if (r_ld_dest != '0) begin
                    rf_we    = 1'b1;
                    rf_waddr = r_ld_dest;
                    rf_wdata = r_ld_ok ? ld_word : '0;
                    o_res.reg_write = 1'b1;
                    o_res.reg_dest  = r_ld_dest;
                    o_res.reg_value = r_ld_ok ? ld_word : '0;
                end
                o_res.next_pc = r_pc;
                o_res.halted  = r_halt;
                o_res_push    = 1'b1;
            end
        endcase
    end

    assign o_clearing = (r_state == S_CLR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_row <= '0;
            r_pc      <= '0;
            r_halt    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= n_clr_row;
            r_pc      <= n_pc;
            r_halt    <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_ld_dest <= n_ld_dest;
        r_ld_ok   <= n_ld_ok;
        r_ld_off  <= n_ld_off;
    end

endmodule

>>> rtl/risc_subset_instruction_core_unit.sv
// Top level of the instruction core: front end, back end and result queue.
//
// Items enter through a queue-style port: the item on i_cmd and the other
// input fields is taken at a rising edge where push is high and full is low.
// Results leave the same way: while empty is low the oldest result is on the
// o_ ports, and it is taken at an edge where pop is high. Every item gives
// exactly one result, in order.
// The back end handles an item as a register read, then execute and
// write-back; a word load adds a read of the data banks after the address
// add. It takes no new item until the result of the last one is pushed.
// After reset the data memory and register file are cleared one row of four
// bytes per cycle; full stays high meanwhile.
// When the receiver stops popping, a two-entry result queue fills, the back
// end stops issuing and the two-entry input queue fills before full rises.
`timescale 1ns / 1ps
module risc_subset_instruction_core_unit
    import rsic_pkg::*;
#(
    parameter int DATA_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_instruction,
    input  logic [15:0] i_byte_address,
    input  logic [7:0]  i_byte_value,
    input  logic [4:0]  i_reg_index,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_next_pc,
    output logic        o_halted,
    output logic        o_reg_write,
    output logic [4:0]  o_reg_dest,
    output logic [31:0] o_reg_value,
    output logic [31:0] o_read_data
);

    t_item head;
    logic  head_valid;
    logic  head_pop;
    logic  clearing;
    t_res  res;
    logic  res_push;
    logic  res_full;
    t_res  out_res;

    rsic_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_hold        (clearing),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_instruction (i_instruction),
        .i_byte_address(i_byte_address),
        .i_byte_value  (i_byte_value),
        .i_reg_index   (i_reg_index),
        .o_head        (head),
        .o_valid       (head_valid),
        .i_pop         (head_pop)
    );

    rsic_back #(
        .DATA_BYTES(DATA_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head),
        .i_item_valid(head_valid),
        .o_item_pop  (head_pop),
        .i_res_room  (~res_full),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_clearing  (clearing)
    );

    rsic_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (out_res),
        .o_empty(empty)
    );

    assign o_next_pc   = out_res.next_pc;
    assign o_halted    = out_res.halted;
    assign o_reg_write = out_res.reg_write;
    assign o_reg_dest  = out_res.reg_dest;
    assign o_reg_value = out_res.reg_value;
    assign o_read_data = out_res.read_data;

endmodule
